// ===== rtl/frq_pkg.sv =====
// Shared types and constants of the ready queue.
package frq_pkg;

	// Fixed widths of the channel fields
	localparam int unsigned CmdBits      = 2;
	localparam int unsigned TidBits      = 16;
	localparam int unsigned StatusBits   = 2;
	localparam int unsigned CountOutBits = 5;

	// Defaults of the top-level parameters
	localparam int unsigned DefQueueDepth = 16;
	localparam int unsigned DefIdBits     = 16;

	// Command codes; code 3 is unused and treated as a no-op
	typedef enum logic [CmdBits-1:0] {
		CMD_ADD   = 2'd0,
		CMD_YIELD = 2'd1,
		CMD_TERM  = 2'd2
	} frq_cmd_t;

	// Result status codes
	typedef enum logic [StatusBits-1:0] {
		ST_OK        = 2'd0,
		ST_EMPTY     = 2'd1,
		ST_NOT_FOUND = 2'd2,
		ST_FULL      = 2'd3
	} frq_status_t;

	// Sequencer states
	typedef enum logic [2:0] {
		S_IDLE,
		S_ADD,
		S_YLD_RD,
		S_YLD_WAIT,
		S_SCAN,
		S_SHIFT,
		S_RESP
	} frq_state_t;

	// Command beat
	typedef struct packed {
		logic [CmdBits-1:0] cmd;
		logic [TidBits-1:0] thread_id;
	} frq_req_t;

	// Result beat
	typedef struct packed {
		logic [StatusBits-1:0]   status;
		logic [TidBits-1:0]      next_thread;
		logic [CountOutBits-1:0] queue_count;
	} frq_rsp_t;

endpackage

// ===== rtl/frq_stream_if.sv =====
// Valid/ready stream channel carrying one payload beat.
interface frq_stream_if #(
	parameter type data_t = logic
) ();
	logic  valid;
	logic  ready;
	data_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/frq_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module frq_ram #(
	parameter int unsigned WIDTH = 16,
	parameter int unsigned DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;
endmodule

// ===== rtl/fifo_ready_queue_with_removal.sv =====
// Top level: FIFO ready queue of thread ids with add, yield and remove-by-id.
// Add writes the new entry at the tail, yield reads the head entry, an unused code goes straight to the result, and
// terminate scans to the hit, then moves the rest up, one entry per cycle.
// One command at a time; the next is taken as soon as the result is staged.
// The single read port of the entry RAM paces the scan and the compaction.
// Reset clears head, count, sequencer and output valid; the store is not cleared.
module fifo_ready_queue_with_removal #(
	parameter int unsigned QUEUE_DEPTH = frq_pkg::DefQueueDepth,
	parameter int unsigned ID_BITS     = frq_pkg::DefIdBits
) (
	input logic          clk,
	input logic          arst_n,
	frq_stream_if.sink   req,
	frq_stream_if.source rsp
);
	import frq_pkg::*;

	localparam int unsigned AW = $clog2(QUEUE_DEPTH);
	localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);

	frq_state_t state_q, state_d;

	// Control state
	logic [AW-1:0] head_q;
	logic [CW-1:0] count_q;
	logic          rsp_valid_q;
	logic          rd_pend_s1;

	// Working registers of the current command
	logic [ID_BITS-1:0] id_q;
	logic [CW-1:0]      idx_q;
	logic [CW-1:0]      rd_off_s1;
	logic [AW-1:0]      rd_slot_s1;
	logic [AW-1:0]      dst_slot_q;
	frq_status_t        res_status_q;
	logic [TidBits-1:0] res_next_q;
	frq_rsp_t           rsp_data_q;

	// RAM port
	logic               ram_we;
	logic [AW-1:0]      ram_waddr;
	logic [ID_BITS-1:0] ram_wdata;
	logic [ID_BITS-1:0] ram_rdata;

	logic          accept;
	logic          full;
	logic          match;
	logic          issue;
	logic          rsp_load;
	logic [AW:0]   slot_sum;
	logic [AW-1:0] slot;
	logic [AW:0]   head_inc;

	assign accept = req.valid && req.ready;
	assign full   = (count_q == CW'(QUEUE_DEPTH));
	assign match  = rd_pend_s1 && (ram_rdata == id_q);

	// Physical slot of queue offset idx_q, wrapped once
	assign slot_sum = (AW+1)'(head_q) + (AW+1)'(idx_q);
	assign slot     = (slot_sum >= (AW+1)'(QUEUE_DEPTH)) ?
		AW'(slot_sum - (AW+1)'(QUEUE_DEPTH)) : AW'(slot_sum);
	assign head_inc = (AW+1)'(head_q) + (AW+1)'(1);

	frq_ram #(
		.WIDTH (ID_BITS),
		.DEPTH (QUEUE_DEPTH)
	) u_entry_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (slot),
		.rdata (ram_rdata)
	);

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					case (req.data.cmd)
						CMD_ADD:   state_d = S_ADD;
						CMD_YIELD: state_d = S_YLD_RD;
						CMD_TERM:  state_d = S_SCAN;
						default:   state_d = S_RESP;
					endcase
				end
			end
			S_ADD:      state_d = S_RESP;
			S_YLD_RD:   state_d = (count_q == '0) ? S_RESP : S_YLD_WAIT;
			S_YLD_WAIT: state_d = S_RESP;
			S_SCAN: begin
				if (match) begin
					state_d = S_SHIFT;
				end else if (!rd_pend_s1 && (idx_q >= count_q)) begin
					state_d = S_RESP;
				end
			end
			S_SHIFT: begin
				if (!issue && !rd_pend_s1) begin
					state_d = S_RESP;
				end
			end
			S_RESP: begin
				if (rsp_load) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// Outputs of the sequencer
	always_comb begin
		req.ready = 1'b0;
		ram_we    = 1'b0;
		ram_waddr = slot;
		ram_wdata = id_q;
		issue     = 1'b0;
		rsp_load  = 1'b0;
		case (state_q)
			S_IDLE: req.ready = 1'b1;
			S_ADD:  ram_we = !full;
			S_SCAN: issue = (idx_q < count_q) && !match;
			S_SHIFT: begin
				issue     = (idx_q < count_q);
				ram_we    = rd_pend_s1;
				ram_waddr = dst_slot_q;
				ram_wdata = ram_rdata;
			end
			S_RESP: rsp_load = !rsp_valid_q || rsp.ready;
			default: ;
		endcase
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			head_q      <= '0;
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
			rd_pend_s1  <= 1'b0;
		end else begin
			state_q    <= state_d;
			rd_pend_s1 <= issue;
			if (state_q == S_ADD && !full) begin
				count_q <= count_q + CW'(1);
			end
			if (state_q == S_YLD_WAIT) begin
				head_q  <= (head_inc == (AW+1)'(QUEUE_DEPTH)) ? '0 : AW'(head_inc);
				count_q <= count_q - CW'(1);
			end
			if (state_q == S_SHIFT && !issue && !rd_pend_s1) begin
				count_q <= count_q - CW'(1);
			end
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// Working registers and result staging
	always_ff @(posedge clk) begin
		if (accept) begin
			id_q         <= ID_BITS'(req.data.thread_id);
			idx_q        <= (req.data.cmd == CMD_ADD) ? count_q : '0;
			res_status_q <= ST_OK;
			res_next_q   <= '0;
		end
		if (issue) begin
			idx_q      <= idx_q + CW'(1);
			rd_off_s1  <= idx_q;
			rd_slot_s1 <= slot;
		end
		case (state_q)
			S_ADD: begin
				if (full) begin
					res_status_q <= ST_FULL;
				end
			end
			S_YLD_RD: begin
				if (count_q == '0) begin
					res_status_q <= ST_EMPTY;
				end
			end
			S_YLD_WAIT: res_next_q <= TidBits'(ram_rdata);
			S_SCAN: begin
				if (match) begin
					// compaction starts with the entry after the hit
					idx_q      <= rd_off_s1 + CW'(1);
					dst_slot_q <= rd_slot_s1;
				end else if (!rd_pend_s1 && (idx_q >= count_q)) begin
					res_status_q <= ST_NOT_FOUND;
				end
			end
			S_SHIFT: begin
				if (rd_pend_s1) begin
					dst_slot_q <= rd_slot_s1;
				end
			end
			default: ;
		endcase
		if (rsp_load) begin
			rsp_data_q.status      <= res_status_q;
			rsp_data_q.next_thread <= res_next_q;
			rsp_data_q.queue_count <= CountOutBits'(count_q);
		end
	end

	assign rsp.valid = rsp_valid_q;
	assign rsp.data  = rsp_data_q;

`ifndef SYNTH
	// Count never exceeds the capacity
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(QUEUE_DEPTH))
		else $error("queue count above capacity");

	// Compaction never writes the slot being read in the same cycle
	a_shift_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SHIFT && ram_we && issue) |-> (ram_waddr != slot))
		else $error("compaction write collides with read");

	// RAM is written only by add and compaction
	a_we_source: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> (state_q == S_ADD || state_q == S_SHIFT))
		else $error("unexpected RAM write");

	// A new result beat is staged only from the result state
	a_rsp_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid_q) |-> ($past(state_q) == S_RESP))
		else $error("result staged outside result state");

	// Successful yield removes exactly one entry
	a_yield_count: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_YLD_WAIT) |=> (count_q == $past(count_q) - CW'(1)))
		else $error("yield count update wrong");
`endif
endmodule

// ===== tb/sv/fifo_ready_queue_with_removal_tb.sv =====
// Testbench: ready queue add/yield/terminate checked against an in-bench queue predictor.
module fifo_ready_queue_with_removal_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import frq_pkg::*;

	localparam int unsigned Depth       = DefQueueDepth;
	localparam int unsigned RandomCmds  = 950;
	localparam int unsigned PhaseLen    = 64;
	localparam int unsigned MaxGap      = 14;
	localparam int unsigned DrainCycles = 2 * Depth + 8;
	localparam logic [CmdBits-1:0] CMD_UNUSED = 2'd3;
	localparam logic [TidBits-1:0] IdMask = {TidBits{1'b1}} >> (TidBits - DefIdBits);

	// Queue predictor plus the store of results still owed by the block
	class ready_queue_scoreboard;
		logic [TidBits-1:0] id_slots [Depth];
		int unsigned        head_slot;
		int unsigned        queued;
		frq_rsp_t           owed_results [$];
		int unsigned        mismatches;

		function new();
			head_slot  = 0;
			queued     = 0;
			mismatches = 0;
			foreach (id_slots[i]) id_slots[i] = '0;
		endfunction

		function int unsigned slot_at(int unsigned offset);
			return (head_slot + offset) % Depth;
		endfunction

		// Apply one accepted command beat and queue up the result it owes
		function void note_command(logic [CmdBits-1:0] cmd, logic [TidBits-1:0] tid);
			frq_rsp_t           owed;
			logic [TidBits-1:0] key;
			int                 found_at;
			key              = tid & IdMask;
			owed.status      = ST_OK;
			owed.next_thread = '0;
			case (cmd)
				CMD_ADD: begin
					if (queued >= Depth) begin
						owed.status = ST_FULL;
					end else begin
						id_slots[slot_at(queued)] = key;
						queued++;
					end
				end
				CMD_YIELD: begin
					if (queued == 0) begin
						owed.status = ST_EMPTY;
					end else begin
						owed.next_thread = id_slots[head_slot];
						head_slot        = (head_slot + 1) % Depth;
						queued--;
					end
				end
				CMD_TERM: begin
					found_at = -1;
					for (int i = 0; i < queued; i++) begin
						if (found_at < 0 && id_slots[slot_at(i)] == key) found_at = i;
					end
					if (found_at < 0) begin
						owed.status = ST_NOT_FOUND;
					end else begin
						// close the gap, keeping order
						for (int i = found_at; i + 1 < queued; i++) begin
							id_slots[slot_at(i)] = id_slots[slot_at(i + 1)];
						end
						queued--;
					end
				end
				default: ; // unused code: no state change
			endcase
			owed.queue_count = CountOutBits'(queued);
			owed_results.push_back(owed);
		endfunction

		// Compare one result beat with the oldest owed result
		function void check_result(frq_rsp_t got);
			frq_rsp_t want;
			if (owed_results.size() == 0) begin
				$error("result beat with nothing owed: status %0d next_thread %0h count %0d",
					got.status, got.next_thread, got.queue_count);
				mismatches++;
				return;
			end
			want = owed_results.pop_front();
			if (got.status !== want.status) begin
				$error("status: expected %0d, actual %0d", want.status, got.status);
				mismatches++;
			end
			if (got.next_thread !== want.next_thread) begin
				$error("next_thread: expected %0h, actual %0h", want.next_thread,
					got.next_thread);
				mismatches++;
			end
			if (got.queue_count !== want.queue_count) begin
				$error("queue_count: expected %0d, actual %0d", want.queue_count,
					got.queue_count);
				mismatches++;
			end
		endfunction

		function logic [TidBits-1:0] pick_queued();
			return id_slots[slot_at($urandom_range(0, queued - 1))];
		endfunction

		function int unsigned pending();
			return owed_results.size();
		endfunction
	endclass

	logic clk;
	logic arst_n;
	bit   idle_on = 1'b1;

	ready_queue_scoreboard sb = new();

	frq_stream_if #(.data_t(frq_req_t)) req_if ();
	frq_stream_if #(.data_t(frq_rsp_t)) rsp_if ();

	fifo_ready_queue_with_removal u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_if),
		.rsp    (rsp_if)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Hard stop in case the block hangs
	initial begin
		#5_000_000;
		$display("Test completed with failures");
		$finish;
	end

	// Id mix: small values for duplicates and hits, extremes, full random
	function automatic logic [TidBits-1:0] draw_id();
		int unsigned roll;
		roll = $urandom_range(0, 99);
		if (roll < 50) return TidBits'($urandom_range(0, 7));
		if (roll < 55) return '1;
		if (roll < 60) return '0;
		if (roll < 65) return {1'b1, {(TidBits-1){1'b0}}};
		return TidBits'($urandom);
	endfunction

	// Drive one command beat after a random gap; valid stays up if no gap follows
	task automatic send_command(input logic [CmdBits-1:0] cmd, input logic [TidBits-1:0] tid);
		int unsigned gap;
		gap = idle_on ? $urandom_range(0, MaxGap) : 0;
		if (gap != 0) begin
			req_if.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_if.valid <= 1'b1;
		req_if.data  <= '{cmd: cmd, thread_id: tid};
		do @(posedge clk); while (!req_if.ready);
		sb.note_command(cmd, tid);
	endtask

	// Result side: random stall per beat, then check on handshake
	initial begin
		int unsigned stall;
		rsp_if.ready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			stall = idle_on ? $urandom_range(0, MaxGap) : 0;
			if (stall != 0) begin
				rsp_if.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			rsp_if.ready <= 1'b1;
			do @(posedge clk); while (!rsp_if.valid);
			sb.check_result(rsp_if.data);
		end
	end

	// Reset, directed cases, random traffic, drain
	initial begin
		int unsigned done_cmds;
		int unsigned loops;
		int unsigned add_pct;
		int unsigned roll;
		logic [TidBits-1:0] tid;
		arst_n       <= 1'b0;
		req_if.valid <= 1'b0;
		req_if.data  <= '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty queue cases and the unused code
		send_command(CMD_YIELD, 16'h1234);
		send_command(CMD_TERM, '0);
		send_command(CMD_UNUSED, '1);
		// fill to the brim, with a duplicate of the all-ones id
		send_command(CMD_ADD, '0);
		send_command(CMD_ADD, '1);
		for (int i = 1; i <= 14; i++) begin
			send_command(CMD_ADD, (i == 8) ? '1 : TidBits'(16'h5A00 + i));
		end
		send_command(CMD_ADD, 16'hA5A5);       // full: dropped
		send_command(CMD_TERM, '1);            // first of two matches
		send_command(CMD_TERM, 16'hA5A5);      // miss after a full scan
		send_command(CMD_TERM, 16'h5A0E);      // tail entry
		send_command(CMD_UNUSED, '0);
		send_command(CMD_YIELD, '1);

		// random phases with different add bias and idling on or off
		done_cmds = 0;
		loops     = 0;
		add_pct   = 50;
		while (done_cmds < RandomCmds) begin
			if (loops % PhaseLen == 0) begin
				case ($urandom_range(0, 2))
					0:       add_pct = 85;
					1:       add_pct = 50;
					default: add_pct = 15;
				endcase
				idle_on = ($urandom_range(0, 3) != 0);
			end
			loops++;
			roll = $urandom_range(0, 99);
			if (roll < 3) begin
				send_command(CMD_UNUSED, TidBits'($urandom));
			end else begin
				done_cmds++;
				if (roll < 3 + add_pct * 97 / 100) begin
					send_command(CMD_ADD, draw_id());
				end else if ($urandom_range(0, 1) == 0) begin
					send_command(CMD_YIELD, TidBits'($urandom));
				end else begin
					tid = (sb.queued != 0 && $urandom_range(0, 3) != 0) ?
						sb.pick_queued() : draw_id();
					send_command(CMD_TERM, tid);
				end
			end
		end
		req_if.valid <= 1'b0;

		while (sb.pending() != 0) @(posedge clk);
		repeat (DrainCycles) @(posedge clk);
		if (sb.mismatches == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule
